// ===== sv/leb_pkg.sv =====
// ----------------------------------------------------------------------------
// leb_pkg: shared definitions for the line edit buffer
// Line store sizing, result kinds, control characters and the result struct
// passed from the editor control to the output register.
// ----------------------------------------------------------------------------
package leb_pkg;

    // Line store sizing
    localparam int LINE_BYTES = 256;
    localparam int ADDR_W     = $clog2(LINE_BYTES);
    localparam int FILL_W     = $clog2(LINE_BYTES + 1);

    // Result kinds
    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_ECHO    = 3'd1,
        KIND_BELL    = 3'd2,
        KIND_ERASE   = 3'd3,
        KIND_NEWLINE = 3'd4,
        KIND_DELIVER = 3'd5,
        KIND_EOI     = 3'd6,
        KIND_REFUSED = 3'd7
    } t_kind;

    // Input commands
    localparam logic CMD_CHAR  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // Control characters
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_KILL = 8'h15;
    localparam logic [7:0] CH_DEL  = 8'h7F;

    // Erase count saturates at this value
    localparam logic [7:0] ERASE_MAX = 8'hFF;

    // One result as computed at input transfer time
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;        // zero when the byte comes from the store
        logic [7:0] erase_count;
    } t_result;

endpackage

// ===== sv/line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// line_edit_buffer: terminal line editor with a line store
// Canonical line editing with echo, erase and kill, and in-order delivery
// of the finished line on fetch requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): i_cmd = 0 sends a received
//   character in i_rx_char, i_cmd = 1 asks for the next byte of a finished
//   line. Output channel (o_out_valid / i_out_stall): one result per input
//   transfer, in o_kind, o_data and o_erase_count.
//   Results are registered: a result is valid in the cycle after its input
//   transfer. One item is taken per cycle while the output is not stalled;
//   the line store has one write and one registered read port, and edit
//   writes and drain reads never share a cycle, so no access waits.
//   Stall: while a result waits under i_out_stall, o_in_stall is high and
//   no new item is taken; the store read data holds with the result.
//   Reset (i_rst_n low, synchronous): the block is in editing mode with an
//   empty line and no result pending. The store itself is not cleared;
//   only bytes written in the current line are ever delivered.
// ----------------------------------------------------------------------------
module line_edit_buffer
    import leb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_rx_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_data,
    output logic [7:0] o_erase_count
);

    logic              take;
    logic              busy;
    t_result           result;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;

    // Input transfer
    assign o_in_stall = busy;
    assign take       = i_in_valid && !busy;

    leb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_cmd     (i_cmd),
        .i_rx_char (i_rx_char),
        .o_result  (result),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_re      (re),
        .o_raddr   (raddr)
    );

    leb_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    leb_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (take),
        .i_result      (result),
        .i_rdata       (rdata),
        .i_out_stall   (i_out_stall),
        .o_busy        (busy),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_data        (o_data),
        .o_erase_count (o_erase_count)
    );

endmodule

// ===== sv/leb_ram.sv =====
// ----------------------------------------------------------------------------
// leb_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// its value while no read is enabled.
// ----------------------------------------------------------------------------
module leb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage array and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/leb_ctrl.sv =====
// ----------------------------------------------------------------------------
// leb_ctrl: line editor control
// Holds the mode, fill count, read position and remaining count. Decides
// the result of each transfer and drives the line store write and read.
// ----------------------------------------------------------------------------
module leb_ctrl
    import leb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,      // input transfer this cycle
    input  logic              i_cmd,
    input  logic [7:0]        i_rx_char,
    output t_result           o_result,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [7:0]        o_wdata,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr
);

    typedef enum logic {
        MODE_EDIT,
        MODE_DRAIN
    } t_mode;

    t_mode             r_mode,   n_mode;
    logic [FILL_W-1:0] r_fill,   n_fill;
    logic [FILL_W-1:0] r_rpos,   n_rpos;
    logic [FILL_W-1:0] r_remain, n_remain;
    logic [7:0]        kill_count;

    // Ctrl-U count, saturated to the 8-bit field
    always_comb begin
        if (32'(r_fill) > 32'(ERASE_MAX)) begin
            kill_count = ERASE_MAX;
        end else begin
            kill_count = 8'(r_fill);
        end
    end

    // Next state, result and store access for one item
    always_comb begin
        n_mode   = r_mode;
        n_fill   = r_fill;
        n_rpos   = r_rpos;
        n_remain = r_remain;
        o_result = '{kind: KIND_REFUSED, data: 8'h00, erase_count: 8'h00};
        o_we     = 1'b0;
        o_waddr  = r_fill[ADDR_W-1:0];
        o_wdata  = i_rx_char;
        o_re     = 1'b0;
        o_raddr  = r_rpos[ADDR_W-1:0];

        unique case (r_mode)
            MODE_DRAIN: begin
                if (i_cmd == CMD_FETCH) begin
                    if (r_remain == '0) begin
                        // empty finished line: end of input
                        o_result.kind = KIND_EOI;
                        n_mode        = MODE_EDIT;
                        n_fill        = '0;
                        n_rpos        = '0;
                    end else begin
                        // byte arrives from the registered store read in the next cycle
                        o_result.kind = KIND_DELIVER;
                        o_re          = 1'b1;
                        n_rpos        = r_rpos + FILL_W'(1);
                        n_remain      = r_remain - FILL_W'(1);
                        if (r_remain == FILL_W'(1)) begin
                            n_mode = MODE_EDIT;
                            n_fill = '0;
                            n_rpos = '0;
                        end
                    end
                end
            end
            MODE_EDIT: begin
                if (i_cmd == CMD_CHAR) begin
                    case (i_rx_char) inside
                        CH_EOT: begin
                            o_result.kind = KIND_NONE;
                            n_mode        = MODE_DRAIN;
                            n_remain      = r_fill;
                            n_rpos        = '0;
                        end
                        CH_CR, CH_LF: begin
                            o_result.kind = KIND_NEWLINE;
                            o_result.data = CH_LF;
                            o_wdata       = CH_LF;
                            n_mode        = MODE_DRAIN;
                            n_rpos        = '0;
                            n_remain      = r_fill;
                            if (32'(r_fill) < LINE_BYTES) begin
                                o_we     = 1'b1;
                                n_fill   = r_fill + FILL_W'(1);
                                n_remain = r_fill + FILL_W'(1);
                            end
                        end
                        CH_BS, CH_DEL: begin
                            if (r_fill == '0) begin
                                o_result.kind = KIND_NONE;
                            end else begin
                                o_result.kind        = KIND_ERASE;
                                o_result.erase_count = 8'd1;
                                n_fill               = r_fill - FILL_W'(1);
                            end
                        end
                        CH_KILL: begin
                            if (r_fill == '0) begin
                                o_result.kind = KIND_NONE;
                            end else begin
                                o_result.kind        = KIND_ERASE;
                                o_result.erase_count = kill_count;
                                n_fill               = '0;
                            end
                        end
                        default: begin
                            // ordinary character: store and echo, bell when full
                            if (r_fill >= FILL_W'(LINE_BYTES - 1)) begin
                                o_result.kind = KIND_BELL;
                            end else begin
                                o_result.kind = KIND_ECHO;
                                o_result.data = i_rx_char;
                                o_we          = 1'b1;
                                n_fill        = r_fill + FILL_W'(1);
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_mode = MODE_EDIT;
            end
        endcase

        // nothing moves without a transfer
        if (!i_take) begin
            n_mode   = r_mode;
            n_fill   = r_fill;
            n_rpos   = r_rpos;
            n_remain = r_remain;
            o_we     = 1'b0;
            o_re     = 1'b0;
        end
    end

    // Editor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_EDIT;
            r_fill   <= '0;
            r_rpos   <= '0;
            r_remain <= '0;
        end else begin
            r_mode   <= n_mode;
            r_fill   <= n_fill;
            r_rpos   <= n_rpos;
            r_remain <= n_remain;
        end
    end

    // Fill count never exceeds the store
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= LINE_BYTES)
        else $error("fill count beyond line store");

    // While draining, delivered plus remaining bytes make up the line
    a_drain_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_DRAIN) |-> (32'(r_rpos) + 32'(r_remain) == 32'(r_fill)))
        else $error("read position and remaining count disagree with fill");

    // Editing keeps the read side cleared
    a_edit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_EDIT) |-> (r_rpos == '0 && r_remain == '0))
        else $error("read state not cleared while editing");

    // Store is never written and read in the same cycle
    a_rw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we && o_re))
        else $error("line store written and read together");

endmodule

// ===== sv/leb_out.sv =====
// ----------------------------------------------------------------------------
// leb_out: result register
// Holds one result until the receiver takes it; delivered bytes are taken
// from the line store read data, which holds while the result waits.
// ----------------------------------------------------------------------------
module leb_out
    import leb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    input  logic [7:0] i_rdata,
    input  logic       i_out_stall,
    output logic       o_busy,
    output logic       o_out_valid,
    output logic [2:0] o_kind,
    output logic [7:0] o_data,
    output logic [7:0] o_erase_count
);

    logic    r_valid, n_valid;
    t_result r_result;

    // Valid flag: set on load, cleared when the receiver takes the result
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_busy        = r_valid && i_out_stall;
    assign o_out_valid   = r_valid;
    assign o_kind        = r_result.kind;
    assign o_data        = (r_result.kind == KIND_DELIVER) ? i_rdata : r_result.data;
    assign o_erase_count = r_result.erase_count;

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !o_busy)
        else $error("result register loaded while stalled");

    // Erase count is zero for every kind but erase
    a_count_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.kind != KIND_ERASE) |-> (o_erase_count == 8'h00))
        else $error("erase count on non-erase result");

endmodule

// ===== tb/line_edit_buffer_test.sv =====
// ----------------------------------------------------------------------------
// line_edit_buffer_test: self-checking bench for the line edit buffer
// Drives received characters and fetch requests through the input channel,
// predicts every result with an in-bench copy of the editor state and checks
// each output transfer in order. Covers echo, erase, kill, bell on a full
// line, newline and Ctrl-D line ends, in-order draining, end-of-input and
// refused items, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module line_edit_buffer_test
    import leb_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 100;

    // Editor state copy, expected result queue and result checks
    class line_edit_scoreboard;
        logic [7:0] line_copy [LINE_BYTES];
        int         fill_cnt   = 0;
        int         rd_pos     = 0;
        int         left_cnt   = 0;
        bit         drain_mode = 1'b0;
        t_result    expected_results [$];
        int         mismatches   = 0;
        int         results_seen = 0;
        int         kind_seen [8];

        function void end_line();
            left_cnt   = fill_cnt;
            rd_pos     = 0;
            drain_mode = 1'b1;
        endfunction

        function void back_to_edit();
            fill_cnt   = 0;
            rd_pos     = 0;
            left_cnt   = 0;
            drain_mode = 1'b0;
        endfunction

        // Next result and state update for one accepted item
        function t_result edit_step(logic cmd, logic [7:0] ch);
            t_result r;
            r = '0;
            r.kind = KIND_NONE;
            if (drain_mode) begin
                if (cmd == CMD_CHAR) begin
                    r.kind = KIND_REFUSED;
                end else if (left_cnt == 0) begin
                    r.kind = KIND_EOI;
                    back_to_edit();
                end else begin
                    r.kind = KIND_DELIVER;
                    r.data = line_copy[rd_pos];
                    rd_pos++;
                    left_cnt--;
                    if (left_cnt == 0) back_to_edit();
                end
            end else if (cmd == CMD_FETCH) begin
                r.kind = KIND_REFUSED;
            end else begin
                case (ch)
                    CH_EOT: end_line();
                    CH_CR, CH_LF: begin
                        if (fill_cnt < LINE_BYTES) begin
                            line_copy[fill_cnt] = CH_LF;
                            fill_cnt++;
                        end
                        end_line();
                        r.kind = KIND_NEWLINE;
                        r.data = CH_LF;
                    end
                    CH_BS, CH_DEL: begin
                        if (fill_cnt > 0) begin
                            fill_cnt--;
                            r.kind        = KIND_ERASE;
                            r.erase_count = 8'd1;
                        end
                    end
                    CH_KILL: begin
                        if (fill_cnt > 0) begin
                            r.kind        = KIND_ERASE;
                            r.erase_count = (fill_cnt > 255) ? ERASE_MAX : 8'(fill_cnt);
                            fill_cnt      = 0;
                        end
                    end
                    default: begin
                        if (fill_cnt >= LINE_BYTES - 1) begin
                            r.kind = KIND_BELL;
                        end else begin
                            line_copy[fill_cnt] = ch;
                            fill_cnt++;
                            r.kind = KIND_ECHO;
                            r.data = ch;
                        end
                    end
                endcase
            end
            return r;
        endfunction

        function void note_item(logic cmd, logic [7:0] ch);
            expected_results.push_back(edit_step(cmd, ch));
        endfunction

        function void check_result(logic [2:0] kind, logic [7:0] data, logic [7:0] count);
            t_result e;
            if (expected_results.size() == 0) begin
                $error("result with nothing pending: kind %0d data %0h count %0d",
                       kind, data, count);
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            results_seen++;
            kind_seen[e.kind]++;
            if (kind !== e.kind) begin
                $error("kind: expected %0d, got %0d", e.kind, kind);
                mismatches++;
            end
            if (data !== e.data) begin
                $error("data: expected %0h, got %0h", e.data, data);
                mismatches++;
            end
            if (count !== e.erase_count) begin
                $error("erase_count: expected %0d, got %0d", e.erase_count, count);
                mismatches++;
            end
        endfunction

        // Fetches that bring a finished line back to editing
        function int fetches_to_finish();
            return (left_cnt == 0) ? 1 : left_cnt;
        endfunction
    endclass

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic       in_cmd      = CMD_CHAR;
    logic [7:0] in_char     = 8'h00;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [2:0] out_kind;
    logic [7:0] out_data;
    logic [7:0] out_count;

    line_edit_scoreboard sb;

    int items_sent    = 0;
    int lines_drained = 0;
    int burst_left    = 0;
    bit steady        = 1'b0;
    int hold_requests = 0;
    int quiet_cycles  = 0;

    // Receiver state
    int seen_holds  = 0;
    int hold_left   = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int stall_phase = 0;
    bit stall_next;

    line_edit_buffer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (in_cmd),
        .i_rx_char     (in_char),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_kind        (out_kind),
        .o_data        (out_data),
        .o_erase_count (out_count)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver stall pattern, with a long hold-off on request
    always @(posedge clk) begin
        if (seen_holds != hold_requests) begin
            seen_holds = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 250);
        end
        mode_left--;
        stall_phase++;
        if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else begin
            case (stall_mode)
                0:       stall_next = 1'b0;
                1:       stall_next = ($urandom_range(0, 3) == 0);
                2:       stall_next = ($urandom_range(0, 9) < 7);
                default: stall_next = ((stall_phase % 7) < 3);
            endcase
        end
        out_stall <= stall_next;
    end

    // Output check and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid === 1'b1 && !out_stall)
                sb.check_result(out_kind, out_data, out_count);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL line_edit_buffer");
                $finish;
            end
        end
    end

    // One input transfer; bursts with random gaps unless steady
    task automatic send_item(input logic cmd, input logic [7:0] ch);
        int gap;
        if (!steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_char  <= ch;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        sb.note_item(cmd, ch);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_EOT || c == CH_BS || c == CH_LF || c == CH_CR ||
               c == CH_KILL || c == CH_DEL);
        return c;
    endfunction

    // Fetch a finished line, with the odd refused character mixed in
    task automatic drain_line();
        int n;
        n = sb.fetches_to_finish();
        repeat (n) begin
            if ($urandom_range(0, 11) == 0)
                send_item(CMD_CHAR, 8'($urandom_range(0, 255)));
            send_item(CMD_FETCH, 8'($urandom_range(0, 255)));
        end
        lines_drained++;
    endtask

    // Typed line with occasional erases, then a line end and the drain
    task automatic edit_line(input int len);
        int r;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_item(CMD_CHAR, CH_BS);
            else if (r < 6)
                send_item(CMD_CHAR, CH_DEL);
            else if (r < 8)
                send_item(CMD_CHAR, CH_KILL);
            else
                send_item(CMD_CHAR, plain_char());
        end
        case ($urandom_range(0, 2))
            0:       send_item(CMD_CHAR, CH_CR);
            1:       send_item(CMD_CHAR, CH_LF);
            default: send_item(CMD_CHAR, CH_EOT);
        endcase
        drain_line();
    endtask

    task automatic fill_to_limit();
        while (sb.fill_cnt < LINE_BYTES - 1) send_item(CMD_CHAR, plain_char());
    endtask

    initial begin
        int  random_end;
        bit  held;
        int  r;
        sb   = new();
        held = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: refusals, empty erases, extremes, kill, line ends, EOI
        send_item(CMD_FETCH, 8'h00);
        send_item(CMD_CHAR, CH_BS);
        send_item(CMD_CHAR, CH_DEL);
        send_item(CMD_CHAR, CH_KILL);
        send_item(CMD_CHAR, 8'h00);
        send_item(CMD_CHAR, 8'hFF);
        send_item(CMD_CHAR, 8'h41);
        send_item(CMD_CHAR, CH_BS);
        send_item(CMD_CHAR, CH_DEL);
        send_item(CMD_CHAR, 8'h80);
        send_item(CMD_CHAR, CH_KILL);
        send_item(CMD_CHAR, 8'h31);
        send_item(CMD_CHAR, CH_CR);
        send_item(CMD_CHAR, CH_EOT);
        send_item(CMD_FETCH, 8'hFF);
        send_item(CMD_FETCH, 8'h00);
        send_item(CMD_CHAR, CH_EOT);
        send_item(CMD_FETCH, 8'h00);
        send_item(CMD_CHAR, 8'h7E);
        send_item(CMD_CHAR, CH_LF);
        send_item(CMD_FETCH, 8'h00);
        send_item(CMD_FETCH, 8'h00);
        send_item(CMD_CHAR, 8'h01);
        send_item(CMD_CHAR, CH_EOT);
        send_item(CMD_FETCH, 8'h00);
        wait_drained();

        // Full line: bells, a full kill, then a full line drained
        fill_to_limit();
        repeat (3) send_item(CMD_CHAR, plain_char());
        send_item(CMD_CHAR, CH_BS);
        send_item(CMD_CHAR, plain_char());
        send_item(CMD_CHAR, CH_KILL);
        fill_to_limit();
        send_item(CMD_CHAR, CH_CR);
        drain_line();
        wait_drained();

        random_end = items_sent + RANDOM_ITEMS;

        // Random lines, noise and broken sequences
        while (items_sent < random_end) begin
            steady = ($urandom_range(0, 4) == 0);
            if (!held && items_sent > random_end - RANDOM_ITEMS / 2) begin
                hold_requests++;
                held = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 85) begin
                edit_line(($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                      : $urandom_range(0, 12));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                if (sb.drain_mode) drain_line();
            end
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
        steady = 1'b0;

        wait_drained();
        repeat (4) @(posedge clk);
        if (sb.expected_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_results.size());
            sb.mismatches++;
        end
        $display("run: %0d input transfers, %0d results checked, %0d lines drained",
                 items_sent, sb.results_seen, lines_drained);
        $display("run: %0d bells, %0d erases, %0d end-of-input, %0d refused",
                 sb.kind_seen[KIND_BELL], sb.kind_seen[KIND_ERASE],
                 sb.kind_seen[KIND_EOI], sb.kind_seen[KIND_REFUSED]);
        if (sb.mismatches == 0)
            $display("PASS line_edit_buffer");
        else
            $display("FAIL line_edit_buffer");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/leb_pkg.sv
sv/leb_ram.sv
sv/leb_ctrl.sv
sv/leb_out.sv
sv/line_edit_buffer.sv
tb/line_edit_buffer_test.sv
